// ===== hw/rtl/rrsched_pkg.sv =====
package rrsched_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_DELAY = 2'd1,
      CMD_YIELD = 2'd2,
      CMD_EXIT  = 2'd3
   } cmd_type;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int OUT_TASK_W  = 3;
   localparam int IN_TICK_W   = 16;

   typedef struct packed {
      logic                  idle;
      logic                  start_fresh;
      logic [OUT_TASK_W-1:0] running_task;
   } rsp_item_type;

endpackage

// ===== hw/rtl/rrsched_ram.sv =====
module rrsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/round_robin_scheduler_with_delay_timers.sv =====
// channel  dir  tdata                                       tuser
// req      in   [2:0] timer_index, [18:3] tick_count        [1:0] cmd
// rsp      out  [2:0] running_task, [3] start_fresh, [4] idle  -
//
// tick: walks every timer through the shared decrementer and the timer ram, with a
//   write step for each armed timer, then runs the round-robin search when idle
// delay, yield, exit: round-robin search loop, skipped in idle mode and for a delay
//   with a timer_index out of range; ST_DONE moves the result to the output register
// req_tready is high only in the idle state; a finished result waits while the output
//   register still holds an unaccepted transaction
// reset is synchronous, active high; the timer ram needs no clearing
module round_robin_scheduler_with_delay_timers
   import rrsched_pkg::*;
#(
   parameter int NUM_TASKS  = 8,
   parameter int NUM_TIMERS = 8,
   parameter int TICK_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // timer_index, tick_count
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // running_task, start_fresh, idle
);

   localparam int TASK_W  = $clog2(NUM_TASKS);
   localparam int TIMER_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
   localparam int ENTRY_W = TASK_W + TICK_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [TASK_W-1:0]      slot_ff, slot_in;
   logic [NUM_TASKS-1:0]   susp_ff, susp_in;
   logic [NUM_TASKS-1:0]   fresh_ff, fresh_in;
   logic [NUM_TIMERS-1:0]  armed_ff, armed_in;
   logic                   idle_mode_ff, idle_mode_in;
   logic [TIMER_W-1:0]     walk_ff, walk_in;
   logic [TASK_W-1:0]      cand_ff, cand_in;
   logic [TASK_W-1:0]      steps_ff, steps_in;
   rsp_item_type           pend_ff, pend_in;
   rsp_item_type           rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   ram_we;
   logic [TIMER_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [ENTRY_W-1:0]     ram_rdata;

   cmd_type                cmd;
   logic [2:0]             timer_index;
   logic [IN_TICK_W-1:0]   tick_count;
   logic [6:0]             tix_ext;
   logic [TIMER_W-1:0]     tix_addr;
   logic                   tix_ok;
   logic [31:0]            ticks_ext;
   logic [TICK_WIDTH-1:0]  ticks;
   logic [TICK_WIDTH-1:0]  walk_count;
   logic [TASK_W-1:0]      walk_owner;
   logic                   req_accept;

   function automatic logic [TASK_W-1:0] next_task(input logic [TASK_W-1:0] t);
      if (t == TASK_W'(NUM_TASKS - 1)) begin
         return '0;
      end
      return t + 1'b1;
   endfunction

   function automatic logic [OUT_TASK_W-1:0] out_task(input logic [TASK_W-1:0] t);
      logic [7:0] e;
      e = 8'(t);
      return e[OUT_TASK_W-1:0];
   endfunction

   assign cmd         = cmd_type'(req_tuser);
   assign timer_index = req_tdata[2:0];
   assign tick_count  = req_tdata[18:3];
   assign tix_ext     = 7'(timer_index);
   assign tix_addr    = tix_ext[TIMER_W-1:0];
   assign tix_ok      = 32'(timer_index) < NUM_TIMERS;
   assign ticks_ext   = 32'(tick_count);
   assign ticks       = ticks_ext[TICK_WIDTH-1:0];
   assign walk_count  = ram_rdata[TICK_WIDTH-1:0];
   assign walk_owner  = ram_rdata[ENTRY_W-1:TICK_WIDTH];

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = RSP_TDATA_W'(rsp_ff);

   rrsched_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_timer_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (walk_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      susp_in      = susp_ff;
      fresh_in     = fresh_ff;
      armed_in     = armed_ff;
      idle_mode_in = idle_mode_ff;
      walk_in      = walk_ff;
      cand_in      = cand_ff;
      steps_in     = steps_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = tix_addr;
      ram_wdata    = {slot_ff, ticks};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_accept) begin
               cand_in  = next_task(slot_ff);
               steps_in = '0;
               if (cmd == CMD_TICK) begin
                  walk_in  = '0;
                  state_in = ST_TICK_RD;
               end else if (idle_mode_ff) begin
                  pend_in  = '{idle: 1'b1, start_fresh: 1'b0, running_task: out_task(slot_ff)};
                  state_in = ST_DONE;
               end else begin
                  unique case (cmd)
                     CMD_DELAY: begin
                        if (tix_ok) begin
                           ram_we             = 1'b1;
                           armed_in[tix_addr] = 1'b1;
                           susp_in[slot_ff]   = 1'b1;
                           state_in           = ST_SEARCH;
                        end else begin
                           pend_in  = '{idle: 1'b0, start_fresh: 1'b0,
                                        running_task: out_task(slot_ff)};
                           state_in = ST_DONE;
                        end
                     end
                     CMD_EXIT: begin
                        susp_in[slot_ff]  = 1'b1;
                        fresh_in[slot_ff] = 1'b1;
                        state_in          = ST_SEARCH;
                     end
                     default: begin
                        state_in = ST_SEARCH;
                     end
                  endcase
               end
            end
         end
         ST_TICK_RD, ST_TICK_WR: begin
            if (state_ff == ST_TICK_RD && armed_ff[walk_ff]) begin
               state_in = ST_TICK_WR;
            end else begin
               if (state_ff == ST_TICK_WR) begin
                  if (walk_count == '0) begin
                     susp_in[walk_owner] = 1'b0;
                     armed_in[walk_ff]   = 1'b0;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = walk_ff;
                     ram_wdata = {walk_owner, walk_count - 1'b1};
                  end
               end
               if (walk_ff == TIMER_W'(NUM_TIMERS - 1)) begin
                  if (idle_mode_ff) begin
                     cand_in  = next_task(slot_ff);
                     steps_in = '0;
                     state_in = ST_SEARCH;
                  end else begin
                     pend_in  = '{idle: 1'b0, start_fresh: 1'b0,
                                  running_task: out_task(slot_ff)};
                     state_in = ST_DONE;
                  end
               end else begin
                  walk_in  = walk_ff + 1'b1;
                  state_in = ST_TICK_RD;
               end
            end
         end
         ST_SEARCH: begin
            if (!susp_ff[cand_ff]) begin
               pend_in           = '{idle: 1'b0, start_fresh: fresh_ff[cand_ff],
                                     running_task: out_task(cand_ff)};
               fresh_in[cand_ff] = 1'b0;
               slot_in           = cand_ff;
               idle_mode_in      = 1'b0;
               state_in          = ST_DONE;
            end else if (steps_ff == TASK_W'(NUM_TASKS - 1)) begin
               pend_in      = '{idle: 1'b1, start_fresh: 1'b0, running_task: out_task(slot_ff)};
               idle_mode_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cand_in  = next_task(cand_ff);
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         susp_ff      <= '0;
         fresh_ff     <= {{(NUM_TASKS - 1){1'b1}}, 1'b0};
         armed_ff     <= '0;
         idle_mode_ff <= 1'b0;
         walk_ff      <= '0;
         cand_ff      <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         susp_ff      <= susp_in;
         fresh_ff     <= fresh_in;
         armed_ff     <= armed_in;
         idle_mode_ff <= idle_mode_in;
         walk_ff      <= walk_in;
         cand_ff      <= cand_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

`ifndef SYNTHESIS
   a_idle_all_suspended : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && idle_mode_ff) |-> (&susp_ff))
      else $error("idle while a task is ready");

   a_running_not_suspended : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !idle_mode_ff) |-> !susp_ff[slot_ff])
      else $error("running task is suspended");

   a_idle_not_fresh : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.idle) |-> !rsp_ff.start_fresh)
      else $error("idle result flags a fresh start");
`endif

endmodule
